// ----- rtl/core/pls_pkg.sv -----
package pls_pkg;

    localparam int POS_W      = 32;
    localparam int VEC_W      = 16;
    localparam int CH_W       = 16;
    localparam int RGB_W      = 48;
    localparam int CFG_W      = 48;
    localparam int IDX_W      = 3;
    localparam int MAG_W      = 30;
    localparam int SQ_W       = 64;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = 32;
    localparam int Q_W        = 15;
    localparam int FRAC_W     = 30;
    localparam int X_W        = 31;
    localparam int INT_EXP_W  = 10;
    localparam int FRAC_EXP_W = 6;
    localparam int ROOT_CNT   = 6;

    localparam logic [IDX_W-1:0] REG_LIGHT_X    = 3'd0;
    localparam logic [IDX_W-1:0] REG_LIGHT_Y    = 3'd1;
    localparam logic [IDX_W-1:0] REG_LIGHT_Z    = 3'd2;
    localparam logic [IDX_W-1:0] REG_LIGHT_RGB  = 3'd3;
    localparam logic [IDX_W-1:0] REG_AMBIENT    = 3'd4;
    localparam logic [IDX_W-1:0] REG_DIFFUSE    = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPECULAR   = 3'd6;
    localparam logic [IDX_W-1:0] REG_SHININESS  = 3'd7;

    localparam logic [RGB_W-1:0] RST_LIGHT_RGB = 48'h1000_1000_1000;
    localparam logic [CH_W-1:0]  RST_AMBIENT   = 16'd410;
    localparam logic [CH_W-1:0]  RST_DIFFUSE   = 16'd3686;
    localparam logic [CH_W-1:0]  RST_SPECULAR  = 16'd3686;
    localparam logic [CH_W-1:0]  RST_SHININESS = 16'd12800;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } t_sqrt_st;

    typedef struct packed {
        logic [2:0][VEC_W-1:0] eye;
        logic [2:0][VEC_W-1:0] norm;
        logic                  shadow;
        logic [RGB_W-1:0]      surf;
    } t_item;

    typedef struct packed {
        t_item      item;
        logic [2:0] neg;
        logic       zero;
    } t_dir;

    typedef struct packed {
        t_dir                  dir;
        logic [2:0][MAG_W-1:0] mag;
    } t_geo;

    typedef struct packed {
        logic             shadow;
        logic [RGB_W-1:0] surf;
        logic             lit;
        logic [31:0]      ldn;
        logic             spec_on;
    } t_shade;

    // One digit of the bit-pair square root recurrence.
    function automatic t_sqrt_st sqrt_step(t_sqrt_st s, logic [SQ_W-1:0] b);
        t_sqrt_st        o;
        logic [SQ_W-1:0] t;
        t = s.r + b;
        if (s.v >= t) begin
            o.v = s.v - t;
            o.r = (s.r >> 1) + b;
        end else begin
            o.v = s.v;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

endpackage

// ----- rtl/core/phong_point_light_shade.sv -----
// Phong shading of one surface point under one point light, in fixed point. The block
// takes one point per clock while o_stall is low and returns its colour; it holds no
// state across points besides the configuration registers, which must only be written
// while no point is in flight. Most of the pipeline depth lies in the seven chained
// square-root units (one for the light-vector length, six for the fractional shininess
// bits), each producing one result bit per stage, plus the 15-stage divider that
// normalizes the light vector. When the output is stalled the whole pipeline holds,
// so o_stall follows i_stall whenever a result is waiting.
module phong_point_light_shade
    import pls_pkg::*;
#(
    parameter int COLOR_BITS = 16
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic signed [VEC_W-1:0] i_eye_x,
    input  logic signed [VEC_W-1:0] i_eye_y,
    input  logic signed [VEC_W-1:0] i_eye_z,
    input  logic signed [VEC_W-1:0] i_norm_x,
    input  logic signed [VEC_W-1:0] i_norm_y,
    input  logic signed [VEC_W-1:0] i_norm_z,
    input  logic                    i_in_shadow,
    input  logic [RGB_W-1:0]        i_surface_rgb,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [CH_W-1:0]         o_out_red,
    output logic [CH_W-1:0]         o_out_green,
    output logic [CH_W-1:0]         o_out_blue,
    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    localparam logic [32:0] SAT = (33'd1 << COLOR_BITS) - 33'd1;

    // Configuration registers
    logic [POS_W-1:0] r_light_x, r_light_y, r_light_z;
    logic [RGB_W-1:0] r_light_rgb;
    logic [CH_W-1:0]  r_ka, r_kd, r_ks, r_shine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x   <= '0;
            r_light_y   <= '0;
            r_light_z   <= '0;
            r_light_rgb <= RST_LIGHT_RGB;
            r_ka        <= RST_AMBIENT;
            r_kd        <= RST_DIFFUSE;
            r_ks        <= RST_SPECULAR;
            r_shine     <= RST_SHININESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LIGHT_X:   r_light_x   <= i_cfg_data[POS_W-1:0];
                REG_LIGHT_Y:   r_light_y   <= i_cfg_data[POS_W-1:0];
                REG_LIGHT_Z:   r_light_z   <= i_cfg_data[POS_W-1:0];
                REG_LIGHT_RGB: r_light_rgb <= i_cfg_data[RGB_W-1:0];
                REG_AMBIENT:   r_ka        <= i_cfg_data[CH_W-1:0];
                REG_DIFFUSE:   r_kd        <= i_cfg_data[CH_W-1:0];
                REG_SPECULAR:  r_ks        <= i_cfg_data[CH_W-1:0];
                REG_SHININESS: r_shine     <= i_cfg_data[CH_W-1:0];
            endcase
        end
    end

    logic w_en;
    logic r_s17_vld;

    assign w_en    = !r_s17_vld || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_s17_vld;

    // Stage 1: light vector D = light - point
    t_item              w_item;
    logic signed [32:0] n_s1_d [3];
    logic signed [32:0] r_s1_d [3];
    t_item              r_s1_item;
    logic               r_s1_vld;

    always_comb begin
        w_item.eye    = {i_eye_x, i_eye_y, i_eye_z};
        w_item.norm   = {i_norm_x, i_norm_y, i_norm_z};
        w_item.shadow = i_in_shadow;
        w_item.surf   = i_surface_rgb;
        n_s1_d[0] = $signed({r_light_x[POS_W-1], r_light_x}) - $signed({i_pos_x[POS_W-1], i_pos_x});
        n_s1_d[1] = $signed({r_light_y[POS_W-1], r_light_y}) - $signed({i_pos_y[POS_W-1], i_pos_y});
        n_s1_d[2] = $signed({r_light_z[POS_W-1], r_light_z}) - $signed({i_pos_z[POS_W-1], i_pos_z});
    end

    // Stage 2: sign and magnitude, leading one of the largest magnitude
    logic [32:0] n_s2_mag [3];
    logic [2:0]  n_s2_neg;
    logic [32:0] w_or;
    logic [5:0]  n_s2_msb;
    logic [32:0] r_s2_mag [3];
    logic [2:0]  r_s2_neg;
    logic [5:0]  r_s2_msb;
    logic        r_s2_zero;
    t_item       r_s2_item;
    logic        r_s2_vld;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_s2_neg[c] = r_s1_d[c][32];
            n_s2_mag[c] = n_s2_neg[c] ? 33'(-r_s1_d[c]) : 33'(r_s1_d[c]);
        end
        // The leading one of the OR is the leading one of the maximum.
        w_or     = n_s2_mag[0] | n_s2_mag[1] | n_s2_mag[2];
        n_s2_msb = '0;
        for (int b = 0; b < 33; b++) begin
            if (w_or[b]) begin
                n_s2_msb = 6'(b);
            end
        end
    end

    // Stage 3: shift all three together so that the largest lies in [2^29, 2^30)
    t_geo        n_s3_geo;
    logic [63:0] w_shift [3];
    t_geo        r_s3_geo;
    logic        r_s3_vld;

    always_comb begin
        n_s3_geo.dir.item = r_s2_item;
        n_s3_geo.dir.neg  = r_s2_neg;
        n_s3_geo.dir.zero = r_s2_zero;
        for (int c = 0; c < 3; c++) begin
            if (r_s2_msb > 6'(MAG_W - 1)) begin
                w_shift[c] = 64'(r_s2_mag[c]) >> (r_s2_msb - 6'(MAG_W - 1));
            end else begin
                w_shift[c] = 64'(r_s2_mag[c]) << (6'(MAG_W - 1) - r_s2_msb);
            end
            n_s3_geo.mag[c] = w_shift[c][MAG_W-1:0];
        end
    end

    // Stage 4: squares; stage 5: sum of squares
    logic [2*MAG_W-1:0] r_s4_sq [3];
    t_geo               r_s4_geo;
    logic               r_s4_vld;
    logic [2*MAG_W+1:0] r_s5_sum;
    t_geo               r_s5_geo;
    logic               r_s5_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_d    <= n_s1_d;
            r_s1_item <= w_item;
            r_s2_mag  <= n_s2_mag;
            r_s2_neg  <= n_s2_neg;
            r_s2_msb  <= n_s2_msb;
            r_s2_zero <= (w_or == '0);
            r_s2_item <= r_s1_item;
            r_s3_geo  <= n_s3_geo;
            for (int c = 0; c < 3; c++) begin
                r_s4_sq[c] <= r_s3_geo.mag[c] * r_s3_geo.mag[c];
            end
            r_s4_geo  <= r_s3_geo;
            r_s5_sum  <= (2*MAG_W+2)'(r_s4_sq[0]) + (2*MAG_W+2)'(r_s4_sq[1])
                         + (2*MAG_W+2)'(r_s4_sq[2]);
            r_s5_geo  <= r_s4_geo;
        end
    end

    // Length of the shifted light vector
    logic              w_len_vld;
    logic [ROOT_W-1:0] w_len;
    logic [$bits(t_geo)-1:0] w_len_side;
    t_geo              w_len_geo;

    pls_sqrt_pipe #(
        .SIDE_W ($bits(t_geo))
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s5_vld),
        .i_value (SQ_W'(r_s5_sum)),
        .i_side  (r_s5_geo),
        .o_valid (w_len_vld),
        .o_root  (w_len),
        .o_side  (w_len_side)
    );

    assign w_len_geo = t_geo'(w_len_side);

    // Unit light vector components
    logic                    w_div_vld;
    logic [2:0][Q_W-1:0]     w_quot;
    logic [$bits(t_dir)-1:0] w_div_side;
    t_dir                    w_div_dir;

    pls_div_pipe #(
        .SIDE_W ($bits(t_dir))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_len_vld),
        .i_len   (w_len),
        .i_mag   (w_len_geo.mag),
        .i_side  (w_len_geo.dir),
        .o_valid (w_div_vld),
        .o_quot  (w_quot),
        .o_side  (w_div_side)
    );

    assign w_div_dir = t_dir'(w_div_side);

    // Stages 6 to 13: L.N, reflection, R.E and the power base
    logic signed [VEC_W-1:0] n_s6_l [3];
    logic signed [VEC_W-1:0] r_s6_l [3];
    t_item                   r_s6_item;
    logic                    r_s6_vld;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (w_div_dir.zero) begin
                n_s6_l[c] = '0;
            end else if (w_div_dir.neg[c]) begin
                n_s6_l[c] = -$signed({1'b0, w_quot[c]});
            end else begin
                n_s6_l[c] = $signed({1'b0, w_quot[c]});
            end
        end
    end

    logic signed [31:0]      r_s7_pn [3];
    logic signed [VEC_W-1:0] r_s7_l  [3];
    t_item                   r_s7_item;
    logic                    r_s7_vld;

    logic signed [32:0]      r_s8_ldn;
    logic signed [VEC_W-1:0] r_s8_l [3];
    t_item                   r_s8_item;
    logic                    r_s8_vld;

    logic signed [48:0]      w_s9_prod [3];
    logic signed [49:0]      r_s9_p [3];
    logic signed [32:0]      r_s9_ldn;
    logic signed [VEC_W-1:0] r_s9_l [3];
    t_item                   r_s9_item;
    logic                    r_s9_vld;

    logic [49:0]        w_s10_mag [3];
    logic [21:0]        w_s10_rm  [3];
    logic signed [21:0] n_s10_r   [3];
    logic signed [21:0] r_s10_r   [3];
    logic signed [32:0] r_s10_ldn;
    t_item              r_s10_item;
    logic               r_s10_vld;

    logic signed [37:0] r_s11_re [3];
    logic signed [32:0] r_s11_ldn;
    t_item              r_s11_item;
    logic               r_s11_vld;

    logic signed [39:0] r_s12_rde;
    logic signed [32:0] r_s12_ldn;
    t_item              r_s12_item;
    logic               r_s12_vld;

    logic [X_W-1:0]     n_s13_x;
    t_shade             n_s13_shade;
    logic [X_W-1:0]     r_s13_x;
    t_shade             r_s13_shade;
    logic               r_s13_vld;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_s9_prod[c] = r_s8_ldn * $signed(r_s8_item.norm[2-c]);
            // Round half away from zero on 2 * (L.N) * N / 2^28.
            w_s10_mag[c] = r_s9_p[c][49] ? 50'(-r_s9_p[c]) : 50'(r_s9_p[c]);
            w_s10_rm[c]  = 22'((w_s10_mag[c] + (50'd1 << 27)) >> 28);
            n_s10_r[c]   = (r_s9_p[c][49] ? -$signed(w_s10_rm[c]) : $signed(w_s10_rm[c]))
                           - 22'(r_s9_l[c]);
        end
        if (r_s12_rde <= 0) begin
            n_s13_x = '0;
        end else if (r_s12_rde >= (40'sd1 <<< 28)) begin
            n_s13_x = X_W'(1) << FRAC_W;
        end else begin
            n_s13_x = {r_s12_rde[28:0], 2'b00};
        end
        n_s13_shade.shadow  = r_s12_item.shadow;
        n_s13_shade.surf    = r_s12_item.surf;
        n_s13_shade.lit     = !r_s12_ldn[32];
        n_s13_shade.ldn     = r_s12_ldn[31:0];
        n_s13_shade.spec_on = !r_s12_ldn[32] && (r_s12_rde > 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_s12_vld <= 1'b0;
            r_s13_vld <= 1'b0;
        end else if (w_en) begin
            r_s6_vld  <= w_div_vld;
            r_s7_vld  <= r_s6_vld;
            r_s8_vld  <= r_s7_vld;
            r_s9_vld  <= r_s8_vld;
            r_s10_vld <= r_s9_vld;
            r_s11_vld <= r_s10_vld;
            r_s12_vld <= r_s11_vld;
            r_s13_vld <= r_s12_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_l    <= n_s6_l;
            r_s6_item <= w_div_dir.item;
            for (int c = 0; c < 3; c++) begin
                r_s7_pn[c]  <= r_s6_l[c] * $signed(r_s6_item.norm[2-c]);
                r_s9_p[c]   <= 50'(w_s9_prod[c]) <<< 1;
                r_s11_re[c] <= r_s10_r[c] * $signed(r_s10_item.eye[2-c]);
            end
            r_s7_l     <= r_s6_l;
            r_s7_item  <= r_s6_item;
            r_s8_ldn   <= 33'(r_s7_pn[0]) + 33'(r_s7_pn[1]) + 33'(r_s7_pn[2]);
            r_s8_l     <= r_s7_l;
            r_s8_item  <= r_s7_item;
            r_s9_ldn   <= r_s8_ldn;
            r_s9_l     <= r_s8_l;
            r_s9_item  <= r_s8_item;
            r_s10_r    <= n_s10_r;
            r_s10_ldn  <= r_s9_ldn;
            r_s10_item <= r_s9_item;
            r_s11_ldn  <= r_s10_ldn;
            r_s11_item <= r_s10_item;
            r_s12_rde  <= 40'(r_s11_re[0]) + 40'(r_s11_re[1]) + 40'(r_s11_re[2]);
            r_s12_ldn  <= r_s11_ldn;
            r_s12_item <= r_s11_item;
            r_s13_x     <= n_s13_x;
            r_s13_shade <= n_s13_shade;
        end
    end

    // Specular power
    logic                      w_pow_vld;
    logic [X_W-1:0]            w_pow;
    logic [$bits(t_shade)-1:0] w_pow_side;
    t_shade                    w_pow_shade;

    pls_pow_pipe #(
        .SIDE_W ($bits(t_shade))
    ) u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s13_vld),
        .i_x     (r_s13_x),
        .i_shine (r_shine),
        .i_side  (r_s13_shade),
        .o_valid (w_pow_vld),
        .o_pow   (w_pow),
        .o_side  (w_pow_side)
    );

    assign w_pow_shade = t_shade'(w_pow_side);

    // Stages 14 to 17: colour terms, sum and saturation
    logic [CH_W-1:0] w_surf_c [3];
    logic [CH_W-1:0] w_light_c [3];

    logic [19:0]    r_s14_eff [3];
    logic [X_W-1:0] r_s14_pw;
    logic [31:0]    r_s14_ldn;
    logic           r_s14_on;
    logic           r_s14_vld;

    logic [23:0]    r_s15_amb [3];
    logic [23:0]    r_s15_dco [3];
    logic [19:0]    r_s15_sco [3];
    logic [X_W-1:0] r_s15_pw;
    logic [31:0]    r_s15_ldn;
    logic           r_s15_on;
    logic           r_s15_vld;

    logic [55:0]    w_s16_dp [3];
    logic [50:0]    w_s16_sp [3];
    logic [23:0]    r_s16_amb [3];
    logic [27:0]    r_s16_dif [3];
    logic [20:0]    r_s16_spe [3];
    logic           r_s16_on;
    logic           r_s16_vld;

    logic [28:0]    w_s17_tot [3];
    logic [32:0]    w_s17_cap [3];
    logic [CH_W-1:0] r_s17_out [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_surf_c[c]  = w_pow_shade.surf[RGB_W-1-CH_W*c -: CH_W];
            w_light_c[c] = r_light_rgb[RGB_W-1-CH_W*c -: CH_W];
            w_s16_dp[c]  = r_s15_dco[c] * r_s15_ldn;
            w_s16_sp[c]  = r_s15_sco[c] * r_s15_pw;
            w_s17_tot[c] = 29'(r_s16_amb[c]);
            if (r_s16_on) begin
                w_s17_tot[c] = w_s17_tot[c] + 29'(r_s16_dif[c]) + 29'(r_s16_spe[c]);
            end
            w_s17_cap[c] = (33'(w_s17_tot[c]) > SAT) ? SAT : 33'(w_s17_tot[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s14_vld <= 1'b0;
            r_s15_vld <= 1'b0;
            r_s16_vld <= 1'b0;
            r_s17_vld <= 1'b0;
        end else if (w_en) begin
            r_s14_vld <= w_pow_vld;
            r_s15_vld <= r_s14_vld;
            r_s16_vld <= r_s15_vld;
            r_s17_vld <= r_s16_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_s14_eff[c] <= 20'((32'(w_surf_c[c]) * 32'(w_light_c[c])) >> 12);
                r_s15_amb[c] <= 24'((36'(r_s14_eff[c]) * 36'(r_ka)) >> 12);
                r_s15_dco[c] <= 24'((36'(r_s14_eff[c]) * 36'(r_kd)) >> 12);
                r_s15_sco[c] <= 20'((32'(w_light_c[c]) * 32'(r_ks)) >> 12);
                r_s16_amb[c] <= r_s15_amb[c];
                r_s16_dif[c] <= 28'(w_s16_dp[c] >> 28);
                r_s16_spe[c] <= 21'(w_s16_sp[c] >> FRAC_W);
                r_s17_out[c] <= w_s17_cap[c][CH_W-1:0];
            end
            r_s14_pw  <= w_pow_shade.spec_on ? w_pow : '0;
            r_s14_ldn <= w_pow_shade.ldn;
            r_s14_on  <= !w_pow_shade.shadow && w_pow_shade.lit;
            r_s15_pw  <= r_s14_pw;
            r_s15_ldn <= r_s14_ldn;
            r_s15_on  <= r_s14_on;
            r_s16_on  <= r_s15_on;
        end
    end

    assign o_out_red   = r_s17_out[0];
    assign o_out_green = r_s17_out[1];
    assign o_out_blue  = r_s17_out[2];

endmodule

// ----- rtl/core/pls_sqrt_pipe.sv -----
module pls_sqrt_pipe
    import pls_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_value,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    t_sqrt_st          r_st   [SQRT_STEPS];
    logic              r_vld  [SQRT_STEPS];
    logic [SIDE_W-1:0] r_side [SQRT_STEPS];

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - s));
        t_sqrt_st          w_in;
        logic              w_vld;
        logic [SIDE_W-1:0] w_side;
        t_sqrt_st          n_st;

        if (s == 0) begin : g_head
            assign w_in.v = i_value;
            assign w_in.r = '0;
            assign w_vld  = i_valid;
            assign w_side = i_side;
        end else begin : g_body
            assign w_in   = r_st[s-1];
            assign w_vld  = r_vld[s-1];
            assign w_side = r_side[s-1];
        end

        assign n_st = sqrt_step(w_in, BIT);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s]   <= n_st;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[SQRT_STEPS-1];
    assign o_root  = r_st[SQRT_STEPS-1].r[ROOT_W-1:0];
    assign o_side  = r_side[SQRT_STEPS-1];

endmodule

// ----- rtl/core/pls_div_pipe.sv -----
module pls_div_pipe
    import pls_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [ROOT_W-1:0]     i_len,
    input  logic [2:0][MAG_W-1:0] i_mag,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [2:0][Q_W-1:0]   o_quot,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int REM_W = MAG_W + Q_W + 1;
    localparam int DEN_W = ROOT_W + Q_W;

    logic [2:0][REM_W-1:0] r_rem  [Q_W];
    logic [2:0][Q_W-1:0]   r_quot [Q_W];
    logic [ROOT_W-1:0]     r_len  [Q_W];
    logic                  r_vld  [Q_W];
    logic [SIDE_W-1:0]     r_side [Q_W];

    // Restoring division, one quotient bit per stage, three lanes sharing the divisor.
    for (genvar s = 0; s < Q_W; s++) begin : g_step
        logic [2:0][REM_W-1:0] w_rem;
        logic [2:0][Q_W-1:0]   w_quot;
        logic [ROOT_W-1:0]     w_len;
        logic                  w_vld;
        logic [SIDE_W-1:0]     w_side;
        logic [DEN_W-1:0]      w_den;
        logic [2:0][REM_W-1:0] n_rem;
        logic [2:0][Q_W-1:0]   n_quot;

        if (s == 0) begin : g_head
            always_comb begin
                for (int c = 0; c < 3; c++) begin
                    w_rem[c] = REM_W'({i_mag[c], (Q_W-1)'(0)}) + REM_W'(i_len >> 1);
                end
            end
            assign w_quot = '0;
            assign w_len  = i_len;
            assign w_vld  = i_valid;
            assign w_side = i_side;
        end else begin : g_body
            assign w_rem  = r_rem[s-1];
            assign w_quot = r_quot[s-1];
            assign w_len  = r_len[s-1];
            assign w_vld  = r_vld[s-1];
            assign w_side = r_side[s-1];
        end

        assign w_den = DEN_W'(w_len) << (Q_W - 1 - s);

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                n_rem[c]  = w_rem[c];
                n_quot[c] = w_quot[c];
                if (DEN_W'(w_rem[c]) >= w_den) begin
                    n_rem[c]                = REM_W'(DEN_W'(w_rem[c]) - w_den);
                    n_quot[c][Q_W - 1 - s]  = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_quot[s] <= n_quot;
                r_len[s]  <= w_len;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quot  = r_quot[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

// ----- rtl/core/pls_pow_pipe.sv -----
module pls_pow_pipe
    import pls_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [X_W-1:0]    i_x,
    input  logic [CH_W-1:0]   i_shine,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [X_W-1:0]    o_pow,
    output logic [SIDE_W-1:0] o_side
);

    localparam int IN_SIDE_W = SIDE_W + X_W;
    localparam logic [X_W-1:0] ONE = X_W'(1) << FRAC_W;

    // Integer part of the exponent: square and multiply, one exponent bit per stage.
    logic [X_W-1:0]    r_res  [INT_EXP_W];
    logic [X_W-1:0]    r_base [INT_EXP_W];
    logic [X_W-1:0]    r_x    [INT_EXP_W];
    logic              r_vld  [INT_EXP_W];
    logic [SIDE_W-1:0] r_side [INT_EXP_W];

    for (genvar j = 0; j < INT_EXP_W; j++) begin : g_int
        logic [X_W-1:0]    w_res;
        logic [X_W-1:0]    w_base;
        logic [X_W-1:0]    w_x;
        logic              w_vld;
        logic [SIDE_W-1:0] w_side;
        logic [2*X_W-1:0]  w_pm;
        logic [2*X_W-1:0]  w_ps;
        logic [X_W-1:0]    n_res;
        logic [X_W-1:0]    n_base;

        if (j == 0) begin : g_head
            assign w_res  = ONE;
            assign w_base = i_x;
            assign w_x    = i_x;
            assign w_vld  = i_valid;
            assign w_side = i_side;
        end else begin : g_body
            assign w_res  = r_res[j-1];
            assign w_base = r_base[j-1];
            assign w_x    = r_x[j-1];
            assign w_vld  = r_vld[j-1];
            assign w_side = r_side[j-1];
        end

        assign w_pm   = w_res * w_base;
        assign w_ps   = w_base * w_base;
        assign n_res  = i_shine[FRAC_EXP_W + j] ? X_W'(w_pm >> FRAC_W) : w_res;
        assign n_base = X_W'(w_ps >> FRAC_W);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[j]  <= n_res;
                r_base[j] <= n_base;
                r_x[j]    <= w_x;
                r_side[j] <= w_side;
            end
        end
    end

    // Fraction bits: a chain of repeated square roots of the base, each followed by
    // a conditional multiply stage.
    logic [X_W-1:0]    c_root [ROOT_CNT+1];
    logic [X_W-1:0]    c_res  [ROOT_CNT+1];
    logic              c_vld  [ROOT_CNT+1];
    logic [SIDE_W-1:0] c_side [ROOT_CNT+1];

    logic [X_W-1:0]    r_mroot [ROOT_CNT];
    logic [X_W-1:0]    r_mres  [ROOT_CNT];
    logic              r_mvld  [ROOT_CNT];
    logic [SIDE_W-1:0] r_mside [ROOT_CNT];

    assign c_root[0] = r_x[INT_EXP_W-1];
    assign c_res[0]  = r_res[INT_EXP_W-1];
    assign c_vld[0]  = r_vld[INT_EXP_W-1];
    assign c_side[0] = r_side[INT_EXP_W-1];

    for (genvar k = 0; k < ROOT_CNT; k++) begin : g_root
        logic                 w_svld;
        logic [ROOT_W-1:0]    w_sroot;
        logic [IN_SIDE_W-1:0] w_sside;
        logic [X_W-1:0]       w_root;
        logic [X_W-1:0]       w_res;
        logic [2*X_W-1:0]     w_prod;
        logic [X_W-1:0]       n_res;

        pls_sqrt_pipe #(
            .SIDE_W (IN_SIDE_W)
        ) u_sqrt (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (c_vld[k]),
            .i_value (SQ_W'({c_root[k], FRAC_W'(0)})),
            .i_side  ({c_side[k], c_res[k]}),
            .o_valid (w_svld),
            .o_root  (w_sroot),
            .o_side  (w_sside)
        );

        assign w_root = w_sroot[X_W-1:0];
        assign w_res  = w_sside[X_W-1:0];
        assign w_prod = w_res * w_root;
        assign n_res  = i_shine[FRAC_EXP_W - 1 - k] ? X_W'(w_prod >> FRAC_W) : w_res;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mvld[k] <= 1'b0;
            end else if (i_en) begin
                r_mvld[k] <= w_svld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mroot[k] <= w_root;
                r_mres[k]  <= n_res;
                r_mside[k] <= w_sside[IN_SIDE_W-1:X_W];
            end
        end

        assign c_root[k+1] = r_mroot[k];
        assign c_res[k+1]  = r_mres[k];
        assign c_vld[k+1]  = r_mvld[k];
        assign c_side[k+1] = r_mside[k];
    end

    assign o_valid = c_vld[ROOT_CNT];
    assign o_pow   = c_res[ROOT_CNT];
    assign o_side  = c_side[ROOT_CNT];

endmodule

// ----- rtl/core/pls_checker.sv -----
module pls_checker
    import pls_pkg::*;
#(
    parameter int COLOR_BITS = 16
)
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_stall,
    input logic            o_valid,
    input logic            i_stall,
    input logic [CH_W-1:0] o_out_red,
    input logic [CH_W-1:0] o_out_green,
    input logic [CH_W-1:0] o_out_blue
);

    localparam logic [33:0] SAT = (34'd1 << COLOR_BITS) - 34'd1;

    // The input side backs up only when a result is waiting and is not taken.
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (o_stall == (o_valid && i_stall)))
        else $error("input stall does not follow the output side");

    // A result that is not taken stays as it is.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_red)
            && $stable(o_out_green) && $stable(o_out_blue)))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((34'(o_out_red) <= SAT) && (34'(o_out_green) <= SAT)
            && (34'(o_out_blue) <= SAT)))
        else $error("channel above its saturation level");

endmodule

bind phong_point_light_shade pls_checker #(.COLOR_BITS(COLOR_BITS)) u_pls_checker (.*);
